// ===== rtl/core/pti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_pkg
// Shared types and constants for the palindromic tree insert block.
// ----------------------------------------------------------------------------
package pti_pkg;

    localparam int SYM_W    = 5;
    localparam int ID_W     = 12;
    localparam int LEN_W    = 13;
    localparam int CNT_W    = 32;
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 2;

    localparam int ROOT_IMAG  = 0;
    localparam int ROOT_EMPTY = 1;

    // master tuser bit positions
    localparam int USER_IS_NEW   = 0;
    localparam int USER_OVERFLOW = 1;

    // master tdata field offsets
    localparam int OFS_NODE = 0;
    localparam int OFS_LEN  = OFS_NODE + ID_W;
    localparam int OFS_LINK = OFS_LEN + LEN_W;
    localparam int OFS_OCC  = OFS_LINK + ID_W;
    localparam int OFS_END  = OFS_OCC + CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK_ADDR,
        ST_WALK_LEN,
        ST_WALK_CHAR,
        ST_CHILD_ADDR,
        ST_CHILD_READ,
        ST_CHILD_NODE,
        ST_CREATE,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/palindromic_tree_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_insert
// Palindromic tree (eertree) insert engine over a stream of symbols.
// ----------------------------------------------------------------------------
// One symbol is processed at a time. Each symbol walks suffix links to find
// its longest extendable suffix, then looks up the child; a symbol that
// creates a node under a parent other than the imaginary root adds a second
// walk from the parent's suffix link and a second child lookup. Every walk
// step at a real node reads the single-port node memory, and a step that
// passes the length check then reads the character memory. The node, child
// and character memories need no clearing after reset: nodes are allocated
// in order, and a child entry counts only if the node it names exists and
// records that parent and symbol. The next symbol is taken while a finished
// result waits in the output register.
// ----------------------------------------------------------------------------
module palindromic_tree_insert #(
    parameter int MAX_NODES      = 4096,
    parameter int ALPHABET       = 26,
    parameter int MAX_STRING_LEN = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pti_pkg::S_DATA_W-1:0]    s_axis_tdata,  // symbol, zero pad
    input  logic [pti_pkg::S_USER_W-1:0]    s_axis_tuser,  // new_string
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // node_id, pal_length, link_node, occurrences, zero pad
    output logic [pti_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic [pti_pkg::M_USER_W-1:0]    m_axis_tuser   // is_new, overflow
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int PCW   = $clog2(MAX_STRING_LEN + 1);
    localparam int PW    = $clog2(MAX_STRING_LEN);
    localparam int LW    = PCW;
    localparam int CDEP  = MAX_NODES * ALPHABET;
    localparam int CAW   = $clog2(CDEP);
    localparam int SYM_W = pti_pkg::SYM_W;
    localparam int ID_W  = pti_pkg::ID_W;
    localparam int LEN_W = pti_pkg::LEN_W;
    localparam int CNT_W = pti_pkg::CNT_W;
    localparam int PADW  = pti_pkg::M_DATA_W - pti_pkg::OFS_END;

    typedef struct packed {
        logic [LW-1:0]    len;
        logic [NW-1:0]    link;
        logic [NW-1:0]    parent;
        logic [SYM_W-1:0] sym;
        logic [CNT_W-1:0] hits;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    pti_pkg::t_state r_state, n_state;

    logic [NW-1:0]    r_cur, r_total, r_w, r_wlink, r_cb, r_c, r_p, r_plink;
    logic [NW-1:0]    r_node, r_link;
    logic [PCW-1:0]   r_pos;
    logic [LW-1:0]    r_wlen, r_plen, r_len;
    logic [SYM_W-1:0] r_sym;
    logic [CNT_W-1:0] r_hits;
    logic             r_second, r_fresh, r_reject;

    logic                         r_ovalid;
    logic [pti_pkg::M_DATA_W-1:0] r_odata;
    logic [pti_pkg::M_USER_W-1:0] r_ouser;

    logic              node_we, child_we, char_we;
    logic [NW-1:0]     node_addr;
    logic [CAW-1:0]    child_addr;
    logic [PW-1:0]     char_addr;
    logic [NODE_W-1:0] node_rdata;
    logic [NW-1:0]     child_rdata;
    logic [SYM_W-1:0]  char_rdata;
    t_node             node_wdata, nd, nv;
    logic [NW-1:0]     cbase;
    logic [PCW-1:0]    char_k;
    logic              out_free, accept, c_valid, c_match;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == pti_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // node record view, empty root overridden
    always_comb begin
        nd = t_node'(node_rdata);
        nv = nd;
        if (r_w == NW'(pti_pkg::ROOT_EMPTY)) begin
            nv.len  = '0;
            nv.link = NW'(pti_pkg::ROOT_IMAG);
        end
    end

    assign char_k  = r_pos - nv.len - PCW'(1);
    assign c_valid = (child_rdata >= NW'(2)) && (child_rdata <= r_total)
                     && (child_rdata > r_cb);
    assign c_match = (nd.parent == r_cb) && (nd.sym == r_sym);
    assign cbase   = (r_state == pti_pkg::ST_DONE) ? r_p : r_cb;
    assign child_addr = CAW'(cbase) * CAW'(ALPHABET) + CAW'(r_sym);

    always_comb begin
        node_wdata = '{len: r_len, link: r_link, parent: r_p, sym: r_sym, hits: r_hits};
    end

    // next state and memory controls
    always_comb begin
        n_state   = r_state;
        node_we   = 1'b0;
        child_we  = 1'b0;
        char_we   = 1'b0;
        node_addr = r_w;
        char_addr = char_k[PW-1:0];
        case (r_state)
            pti_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = pti_pkg::ST_CHECK;
                end
            end
            pti_pkg::ST_CHECK: begin
                if (32'(r_sym) >= 32'(ALPHABET) || r_pos == PCW'(MAX_STRING_LEN)) begin
                    n_state = pti_pkg::ST_DONE;
                end else begin
                    n_state = pti_pkg::ST_WALK_ADDR;
                end
            end
            pti_pkg::ST_WALK_ADDR: begin
                if (r_w == NW'(pti_pkg::ROOT_IMAG)) begin
                    n_state = pti_pkg::ST_CHILD_ADDR;
                end else begin
                    n_state = pti_pkg::ST_WALK_LEN;
                end
            end
            pti_pkg::ST_WALK_LEN: begin
                if (nv.len >= r_pos) begin
                    n_state = pti_pkg::ST_WALK_ADDR;
                end else begin
                    n_state = pti_pkg::ST_WALK_CHAR;
                end
            end
            pti_pkg::ST_WALK_CHAR: begin
                if (char_rdata == r_sym) begin
                    n_state = pti_pkg::ST_CHILD_ADDR;
                end else begin
                    n_state = pti_pkg::ST_WALK_ADDR;
                end
            end
            pti_pkg::ST_CHILD_ADDR: begin
                n_state = pti_pkg::ST_CHILD_READ;
            end
            pti_pkg::ST_CHILD_READ: begin
                node_addr = child_rdata;
                if (c_valid) begin
                    n_state = pti_pkg::ST_CHILD_NODE;
                end else if (r_second) begin
                    n_state = pti_pkg::ST_DONE;
                end else begin
                    n_state = pti_pkg::ST_CREATE;
                end
            end
            pti_pkg::ST_CHILD_NODE: begin
                node_addr = r_c;
                if (r_second || c_match) begin
                    n_state = pti_pkg::ST_DONE;
                end else begin
                    n_state = pti_pkg::ST_CREATE;
                end
            end
            pti_pkg::ST_CREATE: begin
                if (r_total >= NW'(MAX_NODES - 1) || r_p == NW'(pti_pkg::ROOT_IMAG)) begin
                    n_state = pti_pkg::ST_DONE;
                end else begin
                    n_state = pti_pkg::ST_WALK_ADDR;
                end
            end
            pti_pkg::ST_DONE: begin
                node_addr = r_node;
                char_addr = r_pos[PW-1:0];
                if (out_free) begin
                    n_state  = pti_pkg::ST_IDLE;
                    node_we  = !r_reject;
                    char_we  = !r_reject;
                    child_we = !r_reject && r_fresh;
                end
            end
            default: begin
                n_state = pti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pti_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // tree control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cur   <= NW'(pti_pkg::ROOT_EMPTY);
            r_total <= NW'(pti_pkg::ROOT_EMPTY);
        end else if (accept && s_axis_tuser[0]) begin
            r_pos <= '0;
            r_cur <= NW'(pti_pkg::ROOT_EMPTY);
        end else if (r_state == pti_pkg::ST_DONE && out_free && !r_reject) begin
            r_pos <= r_pos + PCW'(1);
            r_cur <= r_node;
            if (r_fresh) begin
                r_total <= r_node;
            end
        end
    end

    // per-symbol working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            pti_pkg::ST_IDLE: begin
                r_sym <= s_axis_tdata[SYM_W-1:0];
            end
            pti_pkg::ST_CHECK: begin
                r_reject <= (32'(r_sym) >= 32'(ALPHABET))
                            || (r_pos == PCW'(MAX_STRING_LEN));
                r_w      <= r_cur;
                r_second <= 1'b0;
            end
            pti_pkg::ST_WALK_ADDR: begin
                if (r_w == NW'(pti_pkg::ROOT_IMAG)) begin
                    r_cb <= r_w;
                    if (!r_second) begin
                        r_p <= r_w;
                    end
                end
            end
            pti_pkg::ST_WALK_LEN: begin
                r_wlen  <= nv.len;
                r_wlink <= nv.link;
                if (nv.len >= r_pos) begin
                    r_w <= nv.link;
                end
            end
            pti_pkg::ST_WALK_CHAR: begin
                if (char_rdata == r_sym) begin
                    r_cb <= r_w;
                    if (!r_second) begin
                        r_p     <= r_w;
                        r_plen  <= r_wlen;
                        r_plink <= r_wlink;
                    end
                end else begin
                    r_w <= r_wlink;
                end
            end
            pti_pkg::ST_CHILD_READ: begin
                r_c <= child_rdata;
                if (!c_valid && r_second) begin
                    r_link <= NW'(pti_pkg::ROOT_IMAG);
                end
            end
            pti_pkg::ST_CHILD_NODE: begin
                if (r_second) begin
                    r_link <= c_match ? r_c : NW'(pti_pkg::ROOT_IMAG);
                end else if (c_match) begin
                    r_node  <= r_c;
                    r_len   <= nd.len;
                    r_link  <= nd.link;
                    r_hits  <= (nd.hits == '1) ? nd.hits : nd.hits + CNT_W'(1);
                    r_fresh <= 1'b0;
                end
            end
            pti_pkg::ST_CREATE: begin
                if (r_total >= NW'(MAX_NODES - 1)) begin
                    r_reject <= 1'b1;
                end else begin
                    r_node  <= r_total + NW'(1);
                    r_hits  <= CNT_W'(1);
                    r_fresh <= 1'b1;
                    if (r_p == NW'(pti_pkg::ROOT_IMAG)) begin
                        r_len  <= LW'(1);
                        r_link <= NW'(pti_pkg::ROOT_EMPTY);
                    end else begin
                        r_len    <= r_plen + LW'(2);
                        r_second <= 1'b1;
                        r_w      <= r_plink;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == pti_pkg::ST_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pti_pkg::ST_DONE && out_free) begin
            if (r_reject) begin
                r_odata <= '0;
                r_ouser <= pti_pkg::M_USER_W'(1) << pti_pkg::USER_OVERFLOW;
            end else begin
                r_odata <= {PADW'(0), CNT_W'(r_hits), ID_W'(r_link),
                            LEN_W'(r_len), ID_W'(r_node)};
                r_ouser <= pti_pkg::M_USER_W'(r_fresh) << pti_pkg::USER_IS_NEW;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    pti_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_addr  (node_addr),
        .i_wdata (node_wdata),
        .o_rdata (node_rdata)
    );

    pti_ram #(
        .WIDTH (NW),
        .DEPTH (CDEP)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_addr  (child_addr),
        .i_wdata (r_node),
        .o_rdata (child_rdata)
    );

    pti_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_STRING_LEN)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_addr  (char_addr),
        .i_wdata (r_sym),
        .o_rdata (char_rdata)
    );

endmodule

// ===== rtl/core/pti_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_checker
// Port-level checks for the palindromic tree insert block.
// ----------------------------------------------------------------------------
module pti_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [pti_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic [pti_pkg::S_USER_W-1:0] s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [pti_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic [pti_pkg::M_USER_W-1:0] m_axis_tuser
);

    logic [pti_pkg::CNT_W-1:0] occ;
    logic [pti_pkg::ID_W-1:0]  node;
    logic                      ovf, fresh;

    assign occ   = m_axis_tdata[pti_pkg::OFS_OCC +: pti_pkg::CNT_W];
    assign node  = m_axis_tdata[pti_pkg::OFS_NODE +: pti_pkg::ID_W];
    assign ovf   = m_axis_tuser[pti_pkg::USER_OVERFLOW];
    assign fresh = m_axis_tuser[pti_pkg::USER_IS_NEW];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // rejected symbol gives an all-zero result
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ovf |-> m_axis_tdata == '0 && !fresh)
        else $error("rejected result not cleared");

    // accepted symbol lands on a real node that has been counted
    a_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !ovf |-> node >= pti_pkg::ID_W'(2) && occ != '0)
        else $error("result node or count invalid");

    // a node created now has exactly one occurrence
    a_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && fresh |-> occ == pti_pkg::CNT_W'(1))
        else $error("new node count not one");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind palindromic_tree_insert pti_checker u_pti_checker (.*);

// ===== tb/tb_palindromic_tree_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palindromic_tree_insert
// Self-checking bench for the eertree insert engine. A queue of symbols
// feeds a stream driver; every accepted symbol updates a local copy of the
// tree, whose expected node, length, link, count and flags are compared
// with each result transaction. Short directed strings, random strings
// and broken sequences, then a string run to full length and a run that
// fills the node table. Both stream sides throttle at random.
// ----------------------------------------------------------------------------
module tb_palindromic_tree_insert;
    import pti_pkg::*;

    localparam int TREE_NODES = 4096;
    localparam int ALPHA      = 26;
    localparam int STR_LEN    = 4096;
    localparam int RAND_ITEMS = 1600;
    localparam int CYCLE_CAP  = 3000000;
    localparam int QUIET_LO   = 6000;
    localparam int QUIET_HI   = 12000;
    localparam int IDLE_PCT   = 24;

    typedef struct {
        bit [SYM_W-1:0] sym;
        bit             new_str;
    } sym_item_t;

    typedef struct {
        bit [ID_W-1:0]  node;
        bit [LEN_W-1:0] len;
        bit             is_new;
        bit [ID_W-1:0]  link;
        bit [CNT_W-1:0] occ;
        bit             ovf;
    } tree_result_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;  // symbol, zero pad
    logic [S_USER_W-1:0] s_axis_tuser  = '0;  // new_string
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // node_id, pal_length, link_node, occurrences, pad
    logic [M_USER_W-1:0] m_axis_tuser;        // is_new, overflow

    palindromic_tree_insert #(
        .MAX_NODES      (TREE_NODES),
        .ALPHABET       (ALPHA),
        .MAX_STRING_LEN (STR_LEN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // local copy of the tree
    bit [SYM_W-1:0] ch_store [STR_LEN];
    bit [ID_W-1:0]  child_tbl [TREE_NODES*ALPHA];
    int             node_len [TREE_NODES];
    bit [ID_W-1:0]  sfx_link [TREE_NODES];
    bit [CNT_W-1:0] hits [TREE_NODES];
    int unsigned    node_cnt = ROOT_EMPTY;
    int unsigned    cur_sfx  = ROOT_EMPTY;
    int unsigned    str_pos  = 0;

    sym_item_t    sym_queue[$];
    tree_result_t exp_results[$];

    int unsigned cycles       = 0;
    int unsigned err_cnt      = 0;
    int unsigned sent_cnt     = 0;
    int unsigned got_cnt      = 0;
    int unsigned new_node_cnt = 0;
    int unsigned bad_sym_cnt  = 0;
    int unsigned str_full_cnt = 0;
    int unsigned tbl_full_cnt = 0;

    initial forever #2 i_clk = ~i_clk;

    function automatic bit pal_extends(int unsigned nd, int unsigned sym);
        int k;
        if (nd >= TREE_NODES) return 1'b0;
        k = int'(str_pos) - node_len[nd];
        if (k <= 0 || k > int'(str_pos) + 1) return 1'b0;
        if (k == int'(str_pos) + 1) return 1'b1;
        return ch_store[k-1] == sym;
    endfunction

    function automatic int unsigned walk_links(int unsigned start, int unsigned sym);
        int unsigned p     = start;
        int unsigned steps = 0;
        while (p != ROOT_IMAG && !pal_extends(p, sym)) begin
            if (steps > TREE_NODES || p >= TREE_NODES) return ROOT_IMAG;
            p = sfx_link[p];
            steps++;
        end
        return p;
    endfunction

    function automatic tree_result_t insert_symbol(sym_item_t it);
        tree_result_t r = '{default: '0};
        int unsigned  sym;
        int unsigned  par;
        int unsigned  nd;
        int unsigned  q;
        sym = it.sym;
        if (it.new_str) begin
            str_pos = 0;
            cur_sfx = ROOT_EMPTY;
        end
        if (sym >= ALPHA) begin
            bad_sym_cnt++;
            r.ovf = 1'b1;
            return r;
        end
        if (str_pos >= STR_LEN) begin
            str_full_cnt++;
            r.ovf = 1'b1;
            return r;
        end
        par = walk_links(cur_sfx, sym);
        nd  = child_tbl[par*ALPHA + sym];
        if (nd == 0) begin
            if (node_cnt >= TREE_NODES - 1) begin
                tbl_full_cnt++;
                r.ovf = 1'b1;
                return r;
            end
            node_cnt++;
            nd = node_cnt;
            child_tbl[par*ALPHA + sym] = ID_W'(nd);
            node_len[nd] = node_len[par] + 2;
            if (par == ROOT_IMAG) begin
                sfx_link[nd] = ID_W'(ROOT_EMPTY);
            end else begin
                q = walk_links(sfx_link[par], sym);
                sfx_link[nd] = child_tbl[q*ALPHA + sym];
            end
            r.is_new = 1'b1;
            new_node_cnt++;
        end
        ch_store[str_pos] = SYM_W'(sym);
        str_pos++;
        cur_sfx = nd;
        if (hits[nd] != '1) hits[nd]++;
        r.node = ID_W'(nd);
        r.len  = LEN_W'(node_len[nd]);
        r.link = sfx_link[nd];
        r.occ  = hits[nd];
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("mismatch %s: got %0h want %0h (result %0d, cycle %0d)",
                     what, got, want, got_cnt, cycles);
    endtask

    function automatic bit quiet_window();
        return cycles >= QUIET_LO && cycles < QUIET_HI;
    endfunction

    // input side driver
    always @(posedge i_clk) begin
        sym_item_t it;
        bit        taken;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                it = sym_queue.pop_front();
                exp_results.push_back(insert_symbol(it));
                sent_cnt++;
            end
            if (s_axis_tvalid && !taken) begin
                // hold the transaction until it is taken
            end else if (sym_queue.size() != 0 &&
                         (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= S_DATA_W'(sym_queue[0].sym);
                s_axis_tuser  <= S_USER_W'(sym_queue[0].new_str);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side monitor
    always @(posedge i_clk) begin
        tree_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_cnt++;
            if (exp_results.size() == 0) begin
                flag_mismatch("unexpected result", m_axis_tdata[OFS_NODE +: ID_W], 0);
            end else begin
                want = exp_results.pop_front();
                if (m_axis_tdata[OFS_NODE +: ID_W] != want.node)
                    flag_mismatch("node_id", m_axis_tdata[OFS_NODE +: ID_W], want.node);
                if (m_axis_tdata[OFS_LEN +: LEN_W] != want.len)
                    flag_mismatch("pal_length", m_axis_tdata[OFS_LEN +: LEN_W], want.len);
                if (m_axis_tuser[USER_IS_NEW] != want.is_new)
                    flag_mismatch("is_new", m_axis_tuser[USER_IS_NEW], want.is_new);
                if (m_axis_tdata[OFS_LINK +: ID_W] != want.link)
                    flag_mismatch("link_node", m_axis_tdata[OFS_LINK +: ID_W], want.link);
                if (m_axis_tdata[OFS_OCC +: CNT_W] != want.occ)
                    flag_mismatch("occurrences", m_axis_tdata[OFS_OCC +: CNT_W], want.occ);
                if (m_axis_tuser[USER_OVERFLOW] != want.ovf)
                    flag_mismatch("overflow", m_axis_tuser[USER_OVERFLOW], want.ovf);
            end
        end
        m_axis_tready <= i_rst_n && (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     exp_results.size());
            $display("FAIL palindromic_tree_insert");
            $finish;
        end
    end

    task automatic push_sym(int unsigned s, bit ns);
        sym_item_t it;
        it.sym     = SYM_W'(s);
        it.new_str = ns;
        sym_queue.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (sym_queue.size() != 0 || s_axis_tvalid || exp_results.size() != 0);
    endtask

    initial begin
        int unsigned n_rand;
        int unsigned kind;
        int unsigned slen;
        int unsigned span;
        int unsigned base;
        int unsigned half[$];
        bit          paused;
        int unsigned batches;

        node_len[ROOT_IMAG] = -1;
        sfx_link[ROOT_EMPTY] = ID_W'(ROOT_IMAG);

        // directed: first symbol without a restart, repeats, aba, bad symbols
        push_sym(0, 1'b0);
        push_sym(0, 1'b0);
        push_sym(1, 1'b0);
        push_sym(0, 1'b0);
        push_sym(25, 1'b1);
        push_sym(25, 1'b0);
        push_sym(31, 1'b0);
        push_sym(25, 1'b0);
        push_sym(26, 1'b1);
        push_sym(25, 1'b0);
        push_sym(16, 1'b0);
        push_sym(15, 1'b0);
        push_sym(16, 1'b0);
        push_sym(25, 1'b0);
        push_sym(0, 1'b1);
        push_sym(1, 1'b0);
        push_sym(2, 1'b0);
        push_sym(1, 1'b0);
        push_sym(0, 1'b0);
        push_sym(0, 1'b0);
        push_sym(30, 1'b1);
        push_sym(2, 1'b0);
        push_sym(2, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random strings, mirrored palindromes and noise
        n_rand = 0;
        paused = 1'b0;
        while (n_rand < RAND_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                push_sym($urandom_range(0, 31), $urandom_range(0, 1));
                n_rand++;
            end else begin
                span = ($urandom_range(0, 3) == 0) ? ALPHA : $urandom_range(2, 4);
                base = $urandom_range(0, ALPHA - span);
                if (kind < 22) begin
                    slen = $urandom_range(1, 20);
                    half.delete();
                    repeat (slen) half.push_back(base + $urandom_range(0, span - 1));
                    foreach (half[i]) push_sym(half[i], i == 0);
                    if ($urandom_range(0, 1)) push_sym(base + $urandom_range(0, span - 1), 1'b0);
                    for (int i = slen - 1; i >= 0; i--) push_sym(half[i], 1'b0);
                    n_rand += 2 * slen + 1;
                end else begin
                    slen = $urandom_range(1, 40);
                    for (int i = 0; i < slen; i++) begin
                        if ($urandom_range(0, 49) == 0)
                            push_sym($urandom_range(ALPHA, 31), 1'b0);
                        else
                            push_sym(base + $urandom_range(0, span - 1), i == 0 && kind >= 30);
                    end
                    n_rand += slen;
                end
            end
            if (!paused && n_rand >= RAND_ITEMS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        wait_drained();

        // one string taken to full length, then symbols past the end
        for (int i = 0; i < STR_LEN; i++) push_sym(i % 3, i == 0);
        push_sym(0, 1'b0);
        push_sym(4, 1'b0);
        push_sym(2, 1'b0);
        push_sym(1, 1'b1);
        wait_drained();

        // a run of one letter grows the tree until the node table is full
        push_sym(0, 1'b1);
        batches = 0;
        while (tbl_full_cnt == 0 && batches < 80) begin
            repeat (64) push_sym(0, 1'b0);
            wait_drained();
            batches++;
        end
        push_sym(0, 1'b1);
        push_sym(0, 1'b0);
        push_sym(7, 1'b0);
        push_sym(25, 1'b1);
        push_sym(24, 1'b0);
        push_sym(31, 1'b0);
        wait_drained();

        repeat (100) @(negedge i_clk);
        if (exp_results.size() != 0)
            flag_mismatch("results missing", 0, exp_results.size());
        $display("%0d symbols in, %0d results out, %0d nodes created (%0d in tree)",
                 sent_cnt, got_cnt, new_node_cnt, node_cnt + 1);
        $display("rejected: %0d bad symbols, %0d past string end, %0d on full table",
                 bad_sym_cnt, str_full_cnt, tbl_full_cnt);
        if (err_cnt == 0) begin
            $display("PASS palindromic_tree_insert");
        end else begin
            $display("FAIL palindromic_tree_insert");
        end
        $finish;
    end

endmodule
